/* hw/rtl/apf_pkg.sv */
`default_nettype none

package apf_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int NODE_W    = $clog2(MAX_NODES + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        idx_t  node;
        idx_t  par;
        node_t nxt;
        node_t disc;
        node_t low;
    } stk_entry_t;

    typedef struct packed {
        logic  push;
        logic  flush;
        node_t node;
    } out_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_WR_A,
        S_RD_B,
        S_WR_B,
        S_ROOT,
        S_ROW_RD,
        S_ROW_LD,
        S_SCAN,
        S_DISC_CMP,
        S_POP_LD,
        S_EMIT
    } state_t;

    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

endpackage

`default_nettype wire

/* hw/rtl/articulation_point_finder.sv */
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid/in_ready    edge_end_a, edge_end_b, last_edge
// out       output     out_valid/out_ready  cut_node, cut_valid, last_result
// config    input      APB, pready high     node_count at byte address 0
//
// An edge that is not last is dropped if invalid, else it takes two read-modify-write
// passes on the adjacency RAM port. The last edge starts the depth-first search,
// which tests one adjacency bit per step of its single scan state; a tree edge reloads
// the adjacency row on the way down and after its pop, and a back edge adds a
// discovery-time compare; then every node is checked in turn for output.
// Reset clears all stores at once through per-row valid bits; no clearing pass.
// The output register decouples stalls: emission holds while that register is full and out_ready is low.

module articulation_point_finder
    import apf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [6:0]  edge_end_a,
    input  wire logic [6:0]  edge_end_b,
    input  wire logic        last_edge,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       cut_node,
    output logic             cut_valid,
    output logic             last_result
);

    state_t     state_reg, state_next;
    node_t      ncount_reg;
    node_t      n_eff;
    idx_t       ea_reg, ea_next, eb_reg, eb_next;
    logic       last_reg, last_next;
    node_t      u_reg, u_next;
    node_t      clock_reg, clock_next, clock_inc;
    node_t      sp_reg, sp_next, sp_m1, sp_m2;
    node_t      kids_reg, kids_next;
    idx_t       root_reg, root_next;
    stk_entry_t top_reg, top_next, pop_entry;
    logic [MAX_NODES-1:0] row_reg, row_next;
    node_t      e_reg, e_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [MAX_NODES-1:0] rowv_reg, rowv_next;
    logic [MAX_NODES-1:0] cut_reg, cut_next;

    logic       in_ok;
    node_t      w;
    idx_t       w_idx, u_idx, e_idx;
    logic       w_hit;

    logic                 adj_we;
    idx_t                 adj_waddr, adj_raddr;
    logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
    logic                 disc_we;
    idx_t                 disc_waddr;
    node_t                disc_wdata, disc_rdata;
    logic                 stk_we;
    idx_t                 stk_waddr;
    stk_entry_t           stk_wdata;
    logic [$bits(stk_entry_t)-1:0] stk_rdata;

    out_cmd_t   cmd;
    logic       out_busy;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NODE_COUNT) ? {25'd0, ncount_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= NODE_W'(MAX_NODES);
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            ncount_reg <= pwdata[NODE_W-1:0];
        end
    end

    assign n_eff = (ncount_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : ncount_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_ok     = (edge_end_a != '0) && (edge_end_b != '0) && (edge_end_a <= n_eff)
                       && (edge_end_b <= n_eff) && (edge_end_a != edge_end_b);
    assign clock_inc = clock_reg + NODE_W'(1);
    assign sp_m1     = sp_reg - NODE_W'(1);
    assign sp_m2     = sp_reg - NODE_W'(2);
    assign w         = top_reg.nxt;
    assign w_idx     = w[IDX_W-1:0];
    assign u_idx     = u_reg[IDX_W-1:0];
    assign e_idx     = e_reg[IDX_W-1:0];
    assign w_hit     = row_reg[w_idx] && (w_idx != top_reg.par) && (w_idx != top_reg.node);
    assign pop_entry = stk_entry_t'(stk_rdata);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_ok)
                    begin
                        state_next = S_RD_A;
                    end
                    else if (last_edge)
                    begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_RD_A:   state_next = S_WR_A;
            S_WR_A:   state_next = S_RD_B;
            S_RD_B:   state_next = S_WR_B;
            S_WR_B:   state_next = last_reg ? S_ROOT : S_IDLE;
            S_ROOT:
            begin
                if (u_reg >= n_eff)
                begin
                    state_next = S_EMIT;
                end
                else if (!visited_reg[u_idx])
                begin
                    state_next = S_ROW_RD;
                end
            end
            S_ROW_RD: state_next = S_ROW_LD;
            S_ROW_LD: state_next = S_SCAN;
            S_SCAN:
            begin
                if (w >= n_eff)
                begin
                    state_next = (sp_reg == NODE_W'(1)) ? S_ROOT : S_POP_LD;
                end
                else if (w_hit)
                begin
                    state_next = visited_reg[w_idx] ? S_DISC_CMP : S_ROW_RD;
                end
            end
            S_DISC_CMP: state_next = S_SCAN;
            S_POP_LD:   state_next = S_ROW_RD;
            S_EMIT:
            begin
                if (!out_busy && (e_reg >= n_eff))
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ea_next      = ea_reg;
        eb_next      = eb_reg;
        last_next    = last_reg;
        u_next       = u_reg;
        clock_next   = clock_reg;
        sp_next      = sp_reg;
        kids_next    = kids_reg;
        root_next    = root_reg;
        top_next     = top_reg;
        row_next     = row_reg;
        e_next       = e_reg;
        visited_next = visited_reg;
        rowv_next    = rowv_reg;
        cut_next     = cut_reg;
        adj_we       = 1'b0;
        adj_waddr    = ea_reg;
        adj_wdata    = '0;
        adj_raddr    = top_reg.node;
        disc_we      = 1'b0;
        disc_waddr   = w_idx;
        disc_wdata   = clock_inc;
        stk_we       = 1'b0;
        stk_waddr    = sp_m1[IDX_W-1:0];
        stk_wdata    = top_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ea_next    = IDX_W'(edge_end_a - NODE_W'(1));
                    eb_next    = IDX_W'(edge_end_b - NODE_W'(1));
                    last_next  = last_edge;
                    u_next     = '0;
                    clock_next = '0;
                end
            end
            S_RD_A:
            begin
                adj_raddr = ea_reg;
            end
            S_WR_A:
            begin
                adj_we            = 1'b1;
                adj_waddr         = ea_reg;
                adj_wdata         = rowv_reg[ea_reg] ? adj_rdata : '0;
                adj_wdata[eb_reg] = 1'b1;
                rowv_next[ea_reg] = 1'b1;
            end
            S_RD_B:
            begin
                adj_raddr = eb_reg;
            end
            S_WR_B:
            begin
                adj_we            = 1'b1;
                adj_waddr         = eb_reg;
                adj_wdata         = rowv_reg[eb_reg] ? adj_rdata : '0;
                adj_wdata[ea_reg] = 1'b1;
                rowv_next[eb_reg] = 1'b1;
            end
            S_ROOT:
            begin
                if (u_reg >= n_eff)
                begin
                    e_next = '0;
                end
                else
                begin
                    u_next = u_reg + NODE_W'(1);
                    if (!visited_reg[u_idx])
                    begin
                        clock_next          = clock_inc;
                        disc_we             = 1'b1;
                        disc_waddr          = u_idx;
                        visited_next[u_idx] = 1'b1;
                        top_next            = '{node: u_idx, par: u_idx, nxt: '0,
                                                disc: clock_inc, low: clock_inc};
                        sp_next             = NODE_W'(1);
                        kids_next           = '0;
                        root_next           = u_idx;
                    end
                end
            end
            S_ROW_LD:
            begin
                row_next = rowv_reg[top_reg.node] ? adj_rdata : '0;
            end
            S_SCAN:
            begin
                if (w >= n_eff)
                begin
                    if (sp_reg == NODE_W'(1))
                    begin
                        cut_next[root_reg] = (kids_reg > NODE_W'(1));
                        sp_next            = '0;
                    end
                end
                else if (w_hit && !visited_reg[w_idx])
                begin
                    clock_next          = clock_inc;
                    disc_we             = 1'b1;
                    visited_next[w_idx] = 1'b1;
                    if (sp_reg == NODE_W'(1))
                    begin
                        kids_next = kids_reg + NODE_W'(1);
                    end
                    stk_we        = 1'b1;
                    stk_wdata.nxt = w + NODE_W'(1);
                    top_next      = '{node: w_idx, par: top_reg.node, nxt: '0,
                                      disc: clock_inc, low: clock_inc};
                    sp_next       = sp_reg + NODE_W'(1);
                end
                else
                begin
                    top_next.nxt = w + NODE_W'(1);
                end
            end
            S_DISC_CMP:
            begin
                if (disc_rdata < top_reg.low)
                begin
                    top_next.low = disc_rdata;
                end
            end
            S_POP_LD:
            begin
                top_next = pop_entry;
                if (pop_entry.disc <= top_reg.low)
                begin
                    cut_next[pop_entry.node] = 1'b1;
                end
                if (top_reg.low < pop_entry.low)
                begin
                    top_next.low = top_reg.low;
                end
                sp_next = sp_m1;
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    if (e_reg >= n_eff)
                    begin
                        cmd.flush    = 1'b1;
                        visited_next = '0;
                        rowv_next    = '0;
                        cut_next     = '0;
                    end
                    else
                    begin
                        cmd.push = cut_reg[e_idx];
                        cmd.node = e_reg + NODE_W'(1);
                        e_next   = e_reg + NODE_W'(1);
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            visited_reg <= '0;
            rowv_reg    <= '0;
            cut_reg     <= '0;
            sp_reg      <= '0;
            kids_reg    <= '0;
            clock_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            rowv_reg    <= rowv_next;
            cut_reg     <= cut_next;
            sp_reg      <= sp_next;
            kids_reg    <= kids_next;
            clock_reg   <= clock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        last_reg <= last_next;
        u_reg    <= u_next;
        root_reg <= root_next;
        top_reg  <= top_next;
        row_reg  <= row_next;
        e_reg    <= e_next;
    end

    apf_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    apf_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_disc_ram (
        .clk   (clk),
        .we    (disc_we),
        .waddr (disc_waddr),
        .wdata (disc_wdata),
        .raddr (w_idx),
        .rdata (disc_rdata)
    );

    apf_ram #(
        .WIDTH ($bits(stk_entry_t)),
        .DEPTH (MAX_NODES)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (sp_m2[IDX_W-1:0]),
        .rdata (stk_rdata)
    );

    apf_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .busy        (out_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cut_node    (cut_node),
        .cut_valid   (cut_valid),
        .last_result (last_result)
    );

endmodule

`default_nettype wire

/* hw/rtl/apf_ram.sv */
`default_nettype none

module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/apf_out.sv */
`default_nettype none

module apf_out
    import apf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire out_cmd_t cmd,
    output logic          busy,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [6:0]    cut_node,
    output logic          cut_valid,
    output logic          last_result
);

    logic  pend_reg, pend_next;
    node_t pend_node_reg, pend_node_next;
    logic  valid_reg, valid_next;
    node_t node_reg, node_next;
    logic  cv_reg, cv_next;
    logic  last_reg, last_next;
    logic  can_take;

    assign can_take = !valid_reg || out_ready;
    assign busy     = !can_take;

    always_comb
    begin
        pend_next      = pend_reg;
        pend_node_next = pend_node_reg;
        valid_next     = valid_reg && !out_ready;
        node_next      = node_reg;
        cv_next        = cv_reg;
        last_next      = last_reg;
        if (cmd.push && can_take)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                node_next  = pend_node_reg;
                cv_next    = 1'b1;
                last_next  = 1'b0;
            end
            pend_next      = 1'b1;
            pend_node_next = cmd.node;
        end
        else if (cmd.flush && can_take)
        begin
            valid_next = 1'b1;
            node_next  = pend_reg ? pend_node_reg : '0;
            cv_next    = pend_reg;
            last_next  = 1'b1;
            pend_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_node_reg <= pend_node_next;
        node_reg      <= node_next;
        cv_reg        <= cv_next;
        last_reg      <= last_next;
    end

    assign out_valid   = valid_reg;
    assign cut_node    = node_reg;
    assign cut_valid   = cv_reg;
    assign last_result = last_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
    import apf_pkg::*;

    typedef struct {
        logic [6:0] node;
        logic       valid;
        logic       last;
    } cut_item_t;

    class CutVertexBoard;
        logic [63:0] adj_rows [64];
        logic [6:0]  node_count;
        cut_item_t   pending_cuts [$];
        int          errors;

        function new();
            node_count = 7'd64;
            errors = 0;
            foreach (adj_rows[i]) adj_rows[i] = '0;
        endfunction

        function int active_count();
            return (node_count > 64) ? 64 : node_count;
        endfunction

        function void find_cuts(int n);
            int disc [64];
            int low [64];
            bit cut [64];
            int stk_node [64];
            int stk_next [64];
            int clk_cnt;
            int sp;
            int v;
            int par;
            int w;
            int p;
            int kids;
            bit found;
            cut_item_t res;
            int cnt;
            foreach (disc[i])
            begin
                disc[i] = 0;
                low[i] = 0;
                cut[i] = 0;
            end
            clk_cnt = 0;
            for (int r = 0; r < n; r++)
            begin
                if (disc[r] != 0) continue;
                clk_cnt++;
                disc[r] = clk_cnt;
                low[r] = clk_cnt;
                stk_node[0] = r;
                stk_next[0] = 0;
                sp = 1;
                kids = 0;
                while (sp > 0)
                begin
                    v = stk_node[sp-1];
                    par = (sp >= 2) ? stk_node[sp-2] : v;
                    w = stk_next[sp-1];
                    found = 0;
                    while (w < n)
                    begin
                        if (adj_rows[v][w] && w != par && w != v)
                        begin
                            found = 1;
                            break;
                        end
                        w++;
                    end
                    if (found)
                    begin
                        stk_next[sp-1] = w + 1;
                        if (disc[w] == 0)
                        begin
                            if (sp == 1) kids++;
                            clk_cnt++;
                            disc[w] = clk_cnt;
                            low[w] = clk_cnt;
                            if (sp < 64)
                            begin
                                stk_node[sp] = w;
                                stk_next[sp] = 0;
                                sp++;
                            end
                        end
                        else if (disc[w] < low[v])
                            low[v] = disc[w];
                    end
                    else
                    begin
                        sp--;
                        if (sp > 0)
                        begin
                            p = stk_node[sp-1];
                            if (disc[p] <= low[v]) cut[p] = 1;
                            if (low[v] < low[p]) low[p] = low[v];
                        end
                    end
                end
                cut[r] = (kids > 1);
            end
            cnt = 0;
            for (int u = 0; u < n; u++)
            begin
                if (cut[u])
                begin
                    res.node = u + 1;
                    res.valid = 1;
                    res.last = 0;
                    pending_cuts = {pending_cuts, res};
                    cnt++;
                end
            end
            if (cnt == 0)
            begin
                res.node = 0;
                res.valid = 0;
                res.last = 1;
                pending_cuts = {pending_cuts, res};
            end
            else
                pending_cuts[pending_cuts.size()-1].last = 1;
        endfunction

        function void note_edge(logic [6:0] a, logic [6:0] b, logic last);
            int n;
            n = active_count();
            if (a >= 1 && b >= 1 && a <= n && b <= n && a != b)
            begin
                adj_rows[a-1][b-1] = 1'b1;
                adj_rows[b-1][a-1] = 1'b1;
            end
            if (last)
            begin
                find_cuts(n);
                foreach (adj_rows[i]) adj_rows[i] = '0;
            end
        endfunction

        function void check_cut(logic [6:0] node, logic valid, logic last);
            cut_item_t exp_item;
            if (pending_cuts.size() == 0)
            begin
                $display("%0t: unexpected item node=%0d valid=%0b last=%0b",
                         $time, node, valid, last);
                errors++;
                return;
            end
            exp_item = pending_cuts.pop_front();
            if (node !== exp_item.node)
            begin
                $display("%0t: cut_node expected %0d actual %0d", $time, exp_item.node, node);
                errors++;
            end
            if (valid !== exp_item.valid)
            begin
                $display("%0t: cut_valid expected %0b actual %0b",
                         $time, exp_item.valid, valid);
                errors++;
            end
            if (last !== exp_item.last)
            begin
                $display("%0t: last_result expected %0b actual %0b",
                         $time, exp_item.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [6:0]  edge_end_a;
    logic [6:0]  edge_end_b;
    logic        last_edge;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  cut_node;
    logic        cut_valid;
    logic        last_result;

    CutVertexBoard board;
    bit            quiet;
    int            cycles;

    articulation_point_finder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .edge_end_a  (edge_end_a),
        .edge_end_b  (edge_end_b),
        .last_edge   (last_edge),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cut_node    (cut_node),
        .cut_valid   (cut_valid),
        .last_result (last_result)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1500000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_edge(logic [6:0] a, logic [6:0] b, logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        edge_end_a <= a;
        edge_end_b <= b;
        last_edge <= last;
        do @(posedge clk); while (!in_ready);
        board.note_edge(a, b, last);
    endtask

    task automatic set_node_count(logic [6:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_cuts.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_NODE_COUNT;
        pwdata <= {$urandom_range(0, 1) ? 25'h1ffffff : 25'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.node_count = value;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [6:0] pick_node();
        int n;
        n = board.active_count();
        if (n < 1) n = 1;
        if ($urandom_range(0, 99) < 85) return 7'($urandom_range(1, n));
        return 7'($urandom_range(0, 127));
    endfunction

    task automatic random_graph(int n_edges);
        bit tree;
        int n;
        logic [6:0] a;
        logic [6:0] b;
        tree = $urandom_range(0, 1);
        n = board.active_count();
        for (int i = 0; i < n_edges; i++)
        begin
            if (tree && n >= 2 && $urandom_range(0, 9) != 0)
            begin
                a = 7'((i % (n - 1)) + 2);
                b = 7'($urandom_range(1, a - 1));
            end
            else
            begin
                a = pick_node();
                b = pick_node();
            end
            send_edge(a, b, i == n_edges - 1);
        end
    endtask

    always
    begin
        int stall;
        if (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        else
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_cut(cut_node, cut_valid, last_result);
        end
    end

    initial
    begin
        int sent;
        int k;
        logic [6:0] phases [9] = '{7'd5, 7'd1, 7'd127, 7'd0, 7'd12, 7'd64, 7'd40, 7'd3, 7'd8};
        board = new();
        cycles = 0;
        quiet = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        edge_end_a = '0;
        edge_end_b = '0;
        last_edge = 1'b0;
        out_ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_edge(7'd1, 7'd64, 1'b0);
        send_edge(7'd64, 7'd2, 1'b0);
        send_edge(7'd2, 7'd2, 1'b0);
        send_edge(7'd0, 7'd5, 1'b0);
        send_edge(7'd65, 7'd3, 1'b0);
        send_edge(7'd127, 7'd127, 1'b0);
        send_edge(7'd1, 7'd64, 1'b1);
        send_edge(7'd0, 7'd0, 1'b1);
        set_node_count(7'd3);
        send_edge(7'd1, 7'd2, 1'b0);
        send_edge(7'd2, 7'd3, 1'b1);
        send_edge(7'd1, 7'd2, 1'b0);
        send_edge(7'd2, 7'd3, 1'b0);
        send_edge(7'd3, 7'd1, 1'b1);
        set_node_count(7'd5);
        send_edge(7'd1, 7'd2, 1'b0);
        send_edge(7'd1, 7'd3, 1'b0);
        send_edge(7'd1, 7'd4, 1'b0);
        send_edge(7'd4, 7'd5, 1'b1);
        set_node_count(7'd0);
        send_edge(7'd1, 7'd1, 1'b1);

        for (int ph = 0; ph < 9; ph++)
        begin
            set_node_count(phases[ph]);
            quiet = (ph == 4);
            if (phases[ph] == 64)
                for (int i = 1; i < 64; i++)
                    send_edge(7'(i), 7'(i + 1), i == 63);
            sent = 0;
            while (sent < 45)
            begin
                k = $urandom_range(1, 12);
                random_graph(k);
                sent += k;
            end
        end
        quiet = 0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_cuts.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/apf_pkg.sv
hw/rtl/apf_ram.sv
hw/rtl/apf_out.sv
hw/rtl/articulation_point_finder.sv
tb/tb.sv
